[src/gam_pkg.sv]
// Shared types, codes and constants of the graph adjacency matrix engine.
package gam_pkg;

  localparam int unsigned NumVertices = 256;
  localparam int unsigned IdW         = 8;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned VcountW     = 9;
  localparam int unsigned EcountW     = 16;
  // Width of the bit index field in a row control word (indices up to 1023).
  localparam int unsigned MaxIdxW     = 10;

  localparam logic [VcountW-1:0] VertexLimitReset = 9'd256;

  localparam logic [CmdW-1:0] CMD_INS_VERTEX   = 2'd0;
  localparam logic [CmdW-1:0] CMD_INS_EDGE     = 2'd1;
  localparam logic [CmdW-1:0] CMD_ERASE_VERTEX = 2'd2;

  localparam logic [StatusW-1:0] STATUS_DONE       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EDGE_REJ   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_ERASE_FAIL = 2'd2;
  localparam logic [StatusW-1:0] STATUS_ERASED     = 2'd3;

  typedef enum logic [1:0] {
    ROW_SET,
    ROW_CLEAR,
    ROW_ZERO
  } row_op_e;

  typedef struct packed {
    row_op_e              op;
    logic [MaxIdxW-1:0]   bit_idx;
  } row_ctl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ED_RD,
    S_ED_CHK,
    S_ED_WR_B,
    S_SWEEP,
    S_TAIL,
    S_DONE
  } state_e;

endpackage

[src/gam_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/gam_row_unit.sv]
// Shared row modify unit: sets, clears or zeroes one adjacency row and tests one bit.
module gam_row_unit #(
  parameter int unsigned NUM_VERTICES = gam_pkg::NumVertices,
  localparam int unsigned IdxW = $clog2(NUM_VERTICES)
) (
  input  gam_pkg::row_ctl_t        row_ctl_i,
  input  logic [NUM_VERTICES-1:0]  rd_data_i,
  output logic [NUM_VERTICES-1:0]  wr_data_o,
  output logic                     hit_o
);
  import gam_pkg::*;

  logic [IdxW-1:0]         bit_idx;
  logic [NUM_VERTICES-1:0] mask;

  assign bit_idx = IdxW'(row_ctl_i.bit_idx);
  assign mask    = NUM_VERTICES'(1) << bit_idx;
  assign hit_o   = rd_data_i[bit_idx];

  always_comb begin
    case (row_ctl_i.op)
      ROW_SET:   wr_data_o = rd_data_i | mask;
      ROW_CLEAR: wr_data_o = rd_data_i & ~mask;
      ROW_ZERO:  wr_data_o = '0;
      default:   wr_data_o = '0;
    endcase
  end

endmodule

[src/gam_seq.sv]
// Command sequencer: presence map, counts, adjacency sweep control and result register.
module gam_seq #(
  parameter int unsigned NUM_VERTICES = gam_pkg::NumVertices,
  localparam int unsigned IdxW = $clog2(NUM_VERTICES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gam_pkg::VcountW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gam_pkg::CmdW-1:0]     command_i,
  input  logic [gam_pkg::IdW-1:0]      first_vertex_i,
  input  logic [gam_pkg::IdW-1:0]      second_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gam_pkg::StatusW-1:0]  status_o,
  output logic [gam_pkg::VcountW-1:0]  vertex_count_o,
  output logic [gam_pkg::EcountW-1:0]  edge_count_o,
  output logic                         ram_we_o,
  output logic [IdxW-1:0]              ram_waddr_o,
  output logic [IdxW-1:0]              ram_raddr_o,
  output gam_pkg::row_ctl_t            row_ctl_o,
  input  logic                         row_hit_i
);
  import gam_pkg::*;

  state_e state_q, state_d;

  logic [IdxW-1:0]         cnt_q;
  logic [IdxW-1:0]         wr_idx_q;
  logic                    wr_pend_q;
  logic [IdW-1:0]          a_q, b_q;
  logic [StatusW-1:0]      status_q;
  logic [VcountW-1:0]      vcnt_q, limit_q;
  logic [EcountW-1:0]      ecnt_q;
  logic [NUM_VERTICES-1:0] present_q;
  logic                    out_valid_q;
  logic [StatusW-1:0]      out_status_q;
  logic [VcountW-1:0]      out_vcnt_q;
  logic [EcountW-1:0]      out_ecnt_q;

  logic            a_ok, b_ok, a_pres, b_pres;
  logic [IdxW-1:0] a_idx, b_idx, aq_idx, bq_idx;
  logic            room, edge_ok, erase_ok, last_cnt, publish;

  assign a_ok     = 32'(first_vertex_i) < NUM_VERTICES;
  assign b_ok     = 32'(second_vertex_i) < NUM_VERTICES;
  assign a_idx    = IdxW'(first_vertex_i);
  assign b_idx    = IdxW'(second_vertex_i);
  assign aq_idx   = IdxW'(a_q);
  assign bq_idx   = IdxW'(b_q);
  assign a_pres   = a_ok && present_q[a_idx];
  assign b_pres   = b_ok && present_q[b_idx];
  assign room     = ({1'b0, vcnt_q} + 10'd1) <= {1'b0, limit_q};
  assign edge_ok  = a_pres && b_pres;
  assign erase_ok = a_pres && (vcnt_q != '0);
  assign last_cnt = cnt_q == IdxW'(NUM_VERTICES - 1);
  assign publish  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o     = state_q == S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign vertex_count_o = out_vcnt_q;
  assign edge_count_o   = out_ecnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (last_cnt) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_INS_EDGE:     state_d = edge_ok ? S_ED_RD : S_DONE;
            CMD_ERASE_VERTEX: state_d = erase_ok ? S_SWEEP : S_DONE;
            default:          state_d = S_DONE;
          endcase
        end
      end
      S_ED_RD:   state_d = S_ED_CHK;
      S_ED_CHK:  state_d = row_hit_i ? S_DONE : S_ED_WR_B;
      S_ED_WR_B: state_d = S_DONE;
      S_SWEEP: begin
        if (last_cnt) state_d = S_TAIL;
      end
      S_TAIL:    state_d = S_DONE;
      S_DONE: begin
        if (publish) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // During the erase sweep the row read in one cycle is written back in the next,
  // so one row is finished per cycle. The erased vertex's own row is zeroed.
  always_comb begin
    ram_we_o          = 1'b0;
    ram_waddr_o       = wr_idx_q;
    ram_raddr_o       = cnt_q;
    row_ctl_o.op      = ROW_CLEAR;
    row_ctl_o.bit_idx = MaxIdxW'(a_q);
    case (state_q)
      S_CLEAR: begin
        ram_we_o     = 1'b1;
        ram_waddr_o  = cnt_q;
        row_ctl_o.op = ROW_ZERO;
      end
      S_ED_RD: begin
        ram_raddr_o = aq_idx;
      end
      S_ED_CHK: begin
        row_ctl_o.op      = ROW_SET;
        row_ctl_o.bit_idx = MaxIdxW'(b_q);
        ram_we_o          = !row_hit_i;
        ram_waddr_o       = aq_idx;
        ram_raddr_o       = bq_idx;
      end
      S_ED_WR_B: begin
        row_ctl_o.op = ROW_SET;
        ram_we_o     = 1'b1;
        ram_waddr_o  = bq_idx;
      end
      S_SWEEP: begin
        ram_we_o     = wr_pend_q;
        row_ctl_o.op = (wr_idx_q == aq_idx) ? ROW_ZERO : ROW_CLEAR;
      end
      S_TAIL: begin
        ram_we_o     = 1'b1;
        row_ctl_o.op = (wr_idx_q == aq_idx) ? ROW_ZERO : ROW_CLEAR;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      vcnt_q      <= '0;
      ecnt_q      <= '0;
      limit_q     <= VertexLimitReset;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q     <= '0;
            wr_pend_q <= 1'b0;
            if (command_i == CMD_INS_VERTEX && a_ok && room && !present_q[a_idx]) begin
              present_q[a_idx] <= 1'b1;
              vcnt_q           <= vcnt_q + 1'b1;
            end
          end
        end
        S_ED_CHK: begin
          if (!row_hit_i) ecnt_q <= ecnt_q + 1'b1;
        end
        S_SWEEP: begin
          if (wr_pend_q && row_hit_i) ecnt_q <= ecnt_q - 1'b1;
          wr_pend_q <= 1'b1;
          cnt_q     <= cnt_q + 1'b1;
        end
        S_TAIL: begin
          if (row_hit_i) ecnt_q <= ecnt_q - 1'b1;
          present_q[aq_idx] <= 1'b0;
          vcnt_q            <= vcnt_q - 1'b1;
        end
        default: begin
        end
      endcase
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      a_q <= first_vertex_i;
      b_q <= second_vertex_i;
      case (command_i)
        CMD_INS_EDGE:     status_q <= edge_ok ? STATUS_DONE : STATUS_EDGE_REJ;
        CMD_ERASE_VERTEX: status_q <= erase_ok ? STATUS_ERASED : STATUS_ERASE_FAIL;
        default:          status_q <= STATUS_DONE;
      endcase
    end
    if (state_q == S_ED_CHK && row_hit_i) begin
      status_q <= STATUS_EDGE_REJ;
    end
    if (state_q == S_SWEEP) begin
      wr_idx_q <= cnt_q;
    end
    if (publish) begin
      out_status_q <= status_q;
      out_vcnt_q   <= vcnt_q;
      out_ecnt_q   <= ecnt_q;
    end
  end

endmodule

[src/graph_adjacency_matrix_engine_top.sv]
// Top level of the undirected graph adjacency matrix engine.
// The graph is kept as a presence bit per vertex and a symmetric adjacency matrix
// held in a RAM of NUM_VERTICES rows, one row per vertex, read and written once
// per cycle through a shared row modify unit. After reset the engine zeroes the
// matrix one row per cycle, with in_ready_o low until every row is cleared;
// configuration writes are taken throughout. Commands are handled one at a time:
// insert vertex, an unused command, an edge with a missing endpoint and a failed
// erase go straight to the result; insert edge reads the first endpoint's row,
// then sets the bit in it and reads the second row, then sets the bit there (no
// writes when the edge already exists); erase vertex sweeps every matrix row
// through the single RAM port pair. A finished result sits in the output
// register, and the next transaction may be accepted while it waits to be taken.
module graph_adjacency_matrix_engine_top #(
  parameter int unsigned NUM_VERTICES = gam_pkg::NumVertices
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gam_pkg::VcountW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gam_pkg::CmdW-1:0]     command_i,
  input  logic [gam_pkg::IdW-1:0]      first_vertex_i,
  input  logic [gam_pkg::IdW-1:0]      second_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gam_pkg::StatusW-1:0]  status_o,
  output logic [gam_pkg::VcountW-1:0]  vertex_count_o,
  output logic [gam_pkg::EcountW-1:0]  edge_count_o
);
  import gam_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_VERTICES);

  logic                    ram_we;
  logic [IdxW-1:0]         ram_waddr, ram_raddr;
  logic [NUM_VERTICES-1:0] ram_wdata, ram_rdata;
  row_ctl_t                row_ctl;
  logic                    row_hit;

  gam_seq #(
    .NUM_VERTICES(NUM_VERTICES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .first_vertex_i (first_vertex_i),
    .second_vertex_i(second_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .vertex_count_o (vertex_count_o),
    .edge_count_o   (edge_count_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_raddr_o    (ram_raddr),
    .row_ctl_o      (row_ctl),
    .row_hit_i      (row_hit)
  );

  gam_row_unit #(
    .NUM_VERTICES(NUM_VERTICES)
  ) u_row_unit (
    .row_ctl_i(row_ctl),
    .rd_data_i(ram_rdata),
    .wr_data_o(ram_wdata),
    .hit_o    (row_hit)
  );

  gam_ram #(
    .WIDTH(NUM_VERTICES),
    .DEPTH(NUM_VERTICES)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

[src/gam_checker.sv]
// Port-level checker for the graph adjacency matrix engine, bound to the top level.
module gam_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gam_pkg::StatusW-1:0]  status_o,
  input logic [gam_pkg::VcountW-1:0]  vertex_count_o,
  input logic [gam_pkg::EcountW-1:0]  edge_count_o
);
  import gam_pkg::*;

  // The engine is not ready in the cycle after it accepts a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine ready right after accepting a transaction");

  // A new result only appears after the engine has been working.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without preceding work");

  // The matrix clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input opened before the clearing pass");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(vertex_count_o) && $stable(edge_count_o))
    else $error("stalled result changed or dropped");

endmodule

bind graph_adjacency_matrix_engine_top gam_checker u_gam_checker (.*);
